[design/assert_macros.svh]
// assertion macros for the sha-1 hasher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("label");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("label");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[design/sha1_pkg.sv]
// types and constants for the sha-1 hasher
package sha1_pkg;
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_h0;
    logic [31:0] digest_h1;
    logic [31:0] digest_h2;
    logic [31:0] digest_h3;
    logic [31:0] digest_h4;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_LEN, ST_OUT
  } state_t;

  localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0] K_ROUND [4] = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                           32'hCA62C1D6};
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
endpackage

[design/sha1_round.sv]
// one sha-1 round: the shared compression unit
module sha1_round import sha1_pkg::*; (
  input  logic [6:0]  round,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] e,
  input  logic [31:0] w,
  output logic [31:0] t
);
  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_ROUND[0];
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K_ROUND[1];
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_ROUND[2];
    end else begin
      f = b ^ c ^ d;
      k = K_ROUND[3];
    end
    t = {a[26:0], a[31:27]} + f + e + k + w;
  end
endmodule

[design/sha1_stream_hasher.sv]
// top level of the sha-1 stream hasher
`include "assert_macros.svh"
// Takes one word a cycle while collecting a block. A word that fills the
// 64-byte block holds the input while the working registers are loaded, the
// single round unit runs every round and the result is added into the
// chaining words. A word that ends the message starts the padding, written one
// byte a cycle up to the end of the block. When the length no longer fits, a
// second padded block follows, and each block goes through the same
// compression. The digest is then shown until it is taken, and the input stays
// blocked meanwhile. Bytes are kept in a 16-word memory of 32-bit words, read
// one word a round.
module sha1_stream_hasher import sha1_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  state_t state, state_next;
  logic [31:0] mem [16];
  logic [31:0] wrd;
  logic [31:0] cur;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] t;
  logic [60:0] byte_count;
  logic [5:0]  pos;
  logic [6:0]  round;
  logic        closing;
  logic        last_blk;
  logic [63:0] bits;
  logic [31:0] w_sched;
  logic [31:0] w_use;
  logic [31:0] sched [16];
  logic        accept;
  logic        out_fire;
  logic        full;

  assign accept   = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign bits     = {byte_count, 3'b000};
  assign full     = (pos == 6'd63);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.byte_valid && full) begin
            state_next = ST_LOAD;
          end else if (in_data.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_LOAD:  state_next = ST_ROUND;
      ST_ROUND: if (round == 7'd79) state_next = ST_FOLD;
      ST_FOLD: begin
        if (last_blk) begin
          state_next = ST_OUT;
        end else if (closing) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (pos == 6'd63) begin
          state_next = ST_LOAD;
        end else if (pos == 6'd55 && pos != 6'd0) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN:   if (pos == 6'd63) state_next = ST_LOAD;
      ST_OUT:   if (out_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    out_data.digest_h0 = h[0];
    out_data.digest_h1 = h[1];
    out_data.digest_h2 = h[2];
    out_data.digest_h3 = h[3];
    out_data.digest_h4 = h[4];
  end

  // byte written this cycle, if any
  logic       wr_en;
  logic [7:0] wr_byte;
  logic       pad_first;
  always_comb begin
    wr_en = 1'b0;
    wr_byte = 8'h00;
    if (state == ST_IDLE && accept && in_data.byte_valid) begin
      wr_en = 1'b1;
      wr_byte = in_data.message_byte;
    end else if (state == ST_PAD) begin
      wr_en = 1'b1;
      wr_byte = pad_first ? PAD_BYTE : 8'h00;
    end else if (state == ST_LEN) begin
      wr_en = 1'b1;
      wr_byte = bits[8'(63 - 8 * (pos - LEN_POS)) -: 8];
    end
  end

  logic [31:0] word_in;
  always_comb begin
    word_in = cur;
    unique case (pos[1:0])
      2'd0: word_in[31:24] = wr_byte;
      2'd1: word_in[23:16] = wr_byte;
      2'd2: word_in[15:8]  = wr_byte;
      default: word_in[7:0] = wr_byte;
    endcase
  end

  // cur mirrors the partial word being assembled
  // word 0 is fetched during load, word r+1 during round r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cur <= (pos[1:0] == 2'd3) ? 32'h0 : word_in;
      if (pos[1:0] == 2'd3) mem[pos[5:2]] <= word_in;
    end
    if (state == ST_ROUND) begin
      wrd <= mem[round[3:0] + 4'd1];
    end else begin
      wrd <= mem[4'd0];
    end
  end

  assign w_sched = {sched[13][30:0] ^ sched[8][30:0] ^ sched[2][30:0] ^ sched[0][30:0],
                    sched[13][31] ^ sched[8][31] ^ sched[2][31] ^ sched[0][31]};
  assign w_use = (round < 7'd16) ? wrd : w_sched;

  sha1_round u_round (
    .round(round), .a(a), .b(b), .c(c), .d(d), .e(e), .w(w_use), .t(t)
  );

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
      sched[15] <= w_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      byte_count <= '0;
      pos <= '0;
      round <= '0;
      closing <= 1'b0;
      last_blk <= 1'b0;
      pad_first <= 1'b0;
      for (int i = 0; i < 5; i++) h[i] <= H_INIT[i];
    end else begin
      state <= state_next;
      if (wr_en) pos <= pos + 6'd1;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.byte_valid) byte_count <= byte_count + 61'd1;
            closing <= in_data.end_of_message;
            pad_first <= 1'b1;
            last_blk <= 1'b0;
          end
        end
        ST_LOAD: begin
          round <= '0;
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
        end
        ST_ROUND: begin
          round <= round + 7'd1;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
        end
        ST_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (pos == 6'd55) last_blk <= 1'b1;
        end
        ST_LEN: last_blk <= 1'b1;
        ST_OUT: begin
          if (out_fire) begin
            for (int i = 0; i < 5; i++) h[i] <= H_INIT[i];
            byte_count <= '0;
            pos <= '0;
            closing <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_ready_idle, clk, rst, out_valid, !in_ready)
  `ASSERT_NEXT(a_load_round, clk, rst, state == ST_LOAD, state == ST_ROUND && round == 7'd0)
  `ASSERT_IMPLIES(a_round_range, clk, rst, state == ST_ROUND, round < 7'd80)
endmodule

[tb/tb_top.sv]
// testbench for the sha-1 stream hasher: byte stream driver, digest checker
`timescale 1ns / 1ps
module tb_top;
  import sha1_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  sha1_stream_hasher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0] chain_words [5];
  logic [7:0]  block_buf [64];
  logic [60:0] msg_len;

  in_item_t  pending_words[$];
  out_item_t digest_queue[$];
  int errors = 0;
  int digests_seen = 0;
  int words_sent = 0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, t, wr, k;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    a = chain_words[0]; b = chain_words[1]; c = chain_words[2];
    d = chain_words[3]; e = chain_words[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) wr = w[r];
      else begin
        wr = rotl(w[(r+13)&15] ^ w[(r+8)&15] ^ w[(r+2)&15] ^ w[r&15], 1);
        w[r&15] = wr;
      end
      if (r < 20) f = (b & c) | (~b & d);
      else if (r < 40 || r >= 60) f = b ^ c ^ d;
      else f = (b & c) | (b & d) | (c & d);
      k = K_ROUND[r/20];
      t = rotl(a, 5) + f + e + k + wr;
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain_words[0] += a; chain_words[1] += b; chain_words[2] += c;
    chain_words[3] += d; chain_words[4] += e;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 5; i++) chain_words[i] = H_INIT[i];
    msg_len = '0;
  endtask

  task automatic absorb_word(in_item_t it);
    int pos;
    logic [63:0] bits;
    out_item_t dg;
    if (it.byte_valid) begin
      pos = msg_len[5:0];
      block_buf[pos] = it.message_byte;
      msg_len = msg_len + 1;
      if (pos == 63) compress();
    end
    if (it.end_of_message) begin
      bits = {msg_len, 3'b000};
      pos = msg_len[5:0];
      block_buf[pos] = PAD_BYTE;
      pos++;
      if (pos > LEN_POS) begin
        while (pos < 64) block_buf[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < LEN_POS) block_buf[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) block_buf[LEN_POS + i] = bits[63 - 8*i -: 8];
      compress();
      dg = '{chain_words[0], chain_words[1], chain_words[2], chain_words[3], chain_words[4]};
      digest_queue.push_back(dg);
      restart_hash();
    end
  endtask

  function automatic in_item_t mk(bit v, bit eom, logic [7:0] b);
    in_item_t it;
    it.message_byte = b; it.byte_valid = v; it.end_of_message = eom;
    return it;
  endfunction

  task automatic add_message(int len, bit close_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) pending_words.push_back(mk(0, 0, $urandom_range(0, 255)));
      pending_words.push_back(mk(1, close_with_byte && i == len - 1, $urandom_range(0, 255)));
    end
    if (!close_with_byte || len == 0) pending_words.push_back(mk(0, 1, $urandom_range(0, 255)));
  endtask

  // driver: bursts with random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        absorb_word(in_data);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          burst_left--;
        end
      end
    end
  end

  // monitor with its own stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        digests_seen++;
        if (digest_queue.size() == 0) begin
          $error("unexpected digest %h", out_data);
          errors++;
        end else begin
          out_item_t exp_dg;
          exp_dg = digest_queue.pop_front();
          if (out_data.digest_h0 !== exp_dg.digest_h0) begin
            $error("digest_h0 exp %h got %h", exp_dg.digest_h0, out_data.digest_h0); errors++;
          end
          if (out_data.digest_h1 !== exp_dg.digest_h1) begin
            $error("digest_h1 exp %h got %h", exp_dg.digest_h1, out_data.digest_h1); errors++;
          end
          if (out_data.digest_h2 !== exp_dg.digest_h2) begin
            $error("digest_h2 exp %h got %h", exp_dg.digest_h2, out_data.digest_h2); errors++;
          end
          if (out_data.digest_h3 !== exp_dg.digest_h3) begin
            $error("digest_h3 exp %h got %h", exp_dg.digest_h3, out_data.digest_h3); errors++;
          end
          if (out_data.digest_h4 !== exp_dg.digest_h4) begin
            $error("digest_h4 exp %h got %h", exp_dg.digest_h4, out_data.digest_h4); errors++;
          end
        end
      end
      stall_phase = (stall_phase + 1) % 23;
      if (stall_phase < 8) out_ready <= 1'b1;
      else if (stall_phase < 12) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  initial begin
    int len;
    restart_hash();
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    // directed: empty message, idle words, byte with end, short messages
    pending_words.push_back(mk(0, 0, 8'hff));
    pending_words.push_back(mk(0, 1, 8'h00));
    pending_words.push_back(mk(1, 1, 8'h00));
    pending_words.push_back(mk(1, 1, 8'hff));
    pending_words.push_back(mk(0, 0, 8'h55));
    pending_words.push_back(mk(1, 0, 8'haa));
    pending_words.push_back(mk(0, 1, 8'h00));
    add_message(3, 1);
    add_message(2, 0);
    // random: mostly short messages, a few across the 55/56/63/64 bounds, a few of 110 to 130 bytes
    while (pending_words.size() < 850) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(54, 66);
        1: len = $urandom_range(110, 130);
        default: len = $urandom_range(0, 12);
      endcase
      add_message(len, $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) pending_words.push_back(mk(0, 0, $urandom_range(0, 255)));
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !in_valid);
    wait (digest_queue.size() == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d words, checked %0d digests (empty, padding edges, multi-block)",
             words_sent, digests_seen);
    if (errors == 0 && digest_queue.size() == 0) $display("** sha1_stream_hasher: PASSED **");
    else $display("** sha1_stream_hasher: FAILED **");
    $finish;
  end

  initial begin
    #4ms;
    $display("timeout");
    $display("** sha1_stream_hasher: FAILED **");
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/sha1_pkg.sv
design/sha1_round.sv
design/sha1_stream_hasher.sv
tb/tb_top.sv
